// ===== sv/mccf_pkg.sv =====
// Package for the multi-channel console FIFO: sizes, request and status codes,
// sequencer states and the structs between the top level and the channel table.
// No dependencies.
`default_nettype none

package mccf_pkg;

    localparam int CHANNELS  = 8;
    localparam int OUT_DEPTH = 4096;
    localparam int IN_DEPTH  = 256;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OUT_PW = $clog2(OUT_DEPTH);
    localparam int IN_PW  = $clog2(IN_DEPTH);
    localparam int OUT_AW = $clog2(CHANNELS * OUT_DEPTH);
    localparam int IN_AW  = $clog2(CHANNELS * IN_DEPTH);

    localparam logic signed [15:0] OWNER_NONE = -16'sd1;
    localparam logic [15:0]        COUNT_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_ALLOC     = 3'd0,
        REQ_FREE      = 3'd1,
        REQ_SET_OWNER = 3'd2,
        REQ_QUERY     = 3'd3,
        REQ_OUT_PUSH  = 3'd4,
        REQ_OUT_POP   = 3'd5,
        REQ_IN_PUSH   = 3'd6,
        REQ_IN_POP    = 3'd7
    } req_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_INVALID = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_EMPTY   = 3'd3,
        STAT_NOFREE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                    alloc;
        logic                    clear_used;
        logic                    set_owner;
        logic                    out_wr_adv;
        logic                    out_rd_adv;
        logic                    in_wr_adv;
        logic                    in_rd_adv;
        logic [CH_W-1:0]         alloc_idx;
        logic signed [15:0]      owner;
    } tbl_cmd_t;

    typedef struct packed {
        logic                    valid_ch;
        logic                    free_found;
        logic [CH_W-1:0]         free_idx;
        logic signed [15:0]      owner;
        logic [OUT_PW-1:0]       out_wp;
        logic [OUT_PW-1:0]       out_rp;
        logic [IN_PW-1:0]        in_wp;
        logic [IN_PW-1:0]        in_rp;
        logic                    out_full;
        logic                    out_empty;
        logic                    in_full;
        logic                    in_empty;
    } tbl_view_t;

endpackage

`default_nettype wire

// ===== sv/mccf_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Holds ring bytes; no package dependency.
`default_nettype none

module mccf_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/mccf_table.sv =====
// Channel table: used flags, owners and ring pointers of every channel, with the
// lookup of the addressed channel and the search for the lowest free one. Uses mccf_pkg.
`default_nettype none

module mccf_table (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [3:0]          channel,
    input  wire mccf_pkg::tbl_cmd_t  cmd,
    output mccf_pkg::tbl_view_t      view
);
    import mccf_pkg::*;

    logic                used_reg   [CHANNELS];
    logic signed [15:0]  owner_reg  [CHANNELS];
    logic [OUT_PW-1:0]   out_wp_reg [CHANNELS];
    logic [OUT_PW-1:0]   out_rp_reg [CHANNELS];
    logic [IN_PW-1:0]    in_wp_reg  [CHANNELS];
    logic [IN_PW-1:0]    in_rp_reg  [CHANNELS];

    logic [CH_W-1:0]     idx;
    logic                in_range;
    logic [OUT_PW-1:0]   out_wp_inc;
    logic [OUT_PW-1:0]   out_rp_inc;
    logic [IN_PW-1:0]    in_wp_inc;
    logic [IN_PW-1:0]    in_rp_inc;

    assign in_range = 32'(channel) < CHANNELS;
    assign idx      = channel[CH_W-1:0];

    always_comb begin
        view.valid_ch   = in_range && used_reg[idx];
        view.owner      = owner_reg[idx];
        view.out_wp     = out_wp_reg[idx];
        view.out_rp     = out_rp_reg[idx];
        view.in_wp      = in_wp_reg[idx];
        view.in_rp      = in_rp_reg[idx];
        out_wp_inc = (view.out_wp == OUT_PW'(OUT_DEPTH - 1)) ? '0 : view.out_wp + 1'b1;
        out_rp_inc = (view.out_rp == OUT_PW'(OUT_DEPTH - 1)) ? '0 : view.out_rp + 1'b1;
        in_wp_inc  = (view.in_wp == IN_PW'(IN_DEPTH - 1)) ? '0 : view.in_wp + 1'b1;
        in_rp_inc  = (view.in_rp == IN_PW'(IN_DEPTH - 1)) ? '0 : view.in_rp + 1'b1;
        view.out_full  = out_wp_inc == view.out_rp;
        view.out_empty = view.out_wp == view.out_rp;
        view.in_full   = in_wp_inc == view.in_rp;
        view.in_empty  = view.in_wp == view.in_rp;
        view.free_found = 1'b0;
        view.free_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                view.free_found = 1'b1;
                view.free_idx   = CH_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            if (!aresetn) begin
                used_reg[i]   <= 1'b0;
                owner_reg[i]  <= OWNER_NONE;
                out_wp_reg[i] <= '0;
                out_rp_reg[i] <= '0;
                in_wp_reg[i]  <= '0;
                in_rp_reg[i]  <= '0;
            end else if (cmd.alloc && cmd.alloc_idx == CH_W'(i)) begin
                used_reg[i]   <= 1'b1;
                owner_reg[i]  <= OWNER_NONE;
                out_wp_reg[i] <= '0;
                out_rp_reg[i] <= '0;
                in_wp_reg[i]  <= '0;
                in_rp_reg[i]  <= '0;
            end else if (idx == CH_W'(i)) begin
                if (cmd.clear_used) begin
                    used_reg[i] <= 1'b0;
                end
                if (cmd.set_owner) begin
                    owner_reg[i] <= cmd.owner;
                end
                if (cmd.out_wr_adv) begin
                    out_wp_reg[i] <= out_wp_inc;
                end
                if (cmd.out_rd_adv) begin
                    out_rp_reg[i] <= out_rp_inc;
                end
                if (cmd.in_wr_adv) begin
                    in_wp_reg[i] <= in_wp_inc;
                end
                if (cmd.in_rd_adv) begin
                    in_rp_reg[i] <= in_rp_inc;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/multi_channel_console_fifo.sv =====
// Top level of the multi-channel console FIFO: request sequencer, burst counter,
// result register and the two ring memories. Uses mccf_pkg, mccf_table and mccf_ram.
//
// Each request beat passes the sequencer states in order: ST_IDLE accepts it,
// ST_EXEC looks up the channel table and accesses the ring memory, and
// ST_RESULT holds the result until it is taken; a pop shows the registered
// ring memory read data there. The sequencer handles one beat at a time, so
// a stalled result stalls the request side. Ring memories are not cleared after
// reset; a pop only ever reads a slot pushed since its channel was allocated.
`default_nettype none

module multi_channel_console_fifo (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [3:0]  s_channel,
    input  wire logic [7:0]  s_data_in,
    input  wire logic signed [15:0] s_owner_in,
    input  wire logic        s_burst_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [7:0]       m_data_out,
    output logic [3:0]       m_channel_out,
    output logic signed [15:0] m_owner_out,
    output logic [15:0]      m_burst_count
);
    import mccf_pkg::*;

    state_t              state_reg, state_next;
    logic [15:0]         count_reg, count_next;

    req_t                req_reg;
    logic [3:0]          channel_reg;
    logic [7:0]          data_in_reg;
    logic signed [15:0]  owner_in_reg;
    logic                last_reg;

    status_t             status_reg, status_next;
    logic [3:0]          chan_out_reg, chan_out_next;
    logic signed [15:0]  owner_out_reg, owner_out_next;
    logic [15:0]         shown_reg, shown_next;
    logic                pop_reg, pop_next;
    logic                pop_in_reg, pop_in_next;

    tbl_cmd_t            cmd;
    tbl_view_t           view;
    logic                count_inc;
    logic [CH_W-1:0]     idx;

    logic                out_en, out_we;
    logic [OUT_AW-1:0]   out_addr;
    logic [7:0]          out_rdata;
    logic                in_en, in_we;
    logic [IN_AW-1:0]    in_addr;
    logic [7:0]          in_rdata;

    assign idx = channel_reg[CH_W-1:0];

    mccf_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .channel (channel_reg),
        .cmd     (cmd),
        .view    (view)
    );

    mccf_ram #(.DEPTH(CHANNELS * OUT_DEPTH), .WIDTH(8)) u_out_ram (
        .aclk  (aclk),
        .en    (out_en),
        .we    (out_we),
        .addr  (out_addr),
        .wdata (data_in_reg),
        .rdata (out_rdata)
    );

    mccf_ram #(.DEPTH(CHANNELS * IN_DEPTH), .WIDTH(8)) u_in_ram (
        .aclk  (aclk),
        .en    (in_en),
        .we    (in_we),
        .addr  (in_addr),
        .wdata (data_in_reg),
        .rdata (in_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        chan_out_next  = chan_out_reg;
        owner_out_next = owner_out_reg;
        shown_next     = shown_reg;
        pop_next       = pop_reg;
        pop_in_next    = pop_in_reg;
        cmd            = '0;
        cmd.alloc_idx  = view.free_idx;
        cmd.owner      = owner_in_reg;
        count_inc      = 1'b0;
        out_en         = 1'b0;
        out_we         = 1'b0;
        in_en          = 1'b0;
        in_we          = 1'b0;
        out_addr = OUT_AW'(idx) * OUT_AW'(OUT_DEPTH) + OUT_AW'(view.out_rp);
        in_addr  = IN_AW'(idx) * IN_AW'(IN_DEPTH) + IN_AW'(view.in_rp);
        if (req_reg == REQ_OUT_PUSH) begin
            out_addr = OUT_AW'(idx) * OUT_AW'(OUT_DEPTH) + OUT_AW'(view.out_wp);
        end
        if (req_reg == REQ_IN_PUSH) begin
            in_addr = IN_AW'(idx) * IN_AW'(IN_DEPTH) + IN_AW'(view.in_wp);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                status_next    = STAT_OK;
                chan_out_next  = '0;
                owner_out_next = '0;
                pop_next       = 1'b0;
                pop_in_next    = 1'b0;
                if (req_reg == REQ_ALLOC) begin
                    if (view.free_found) begin
                        cmd.alloc     = 1'b1;
                        chan_out_next = 4'(view.free_idx);
                    end else begin
                        status_next = STAT_NOFREE;
                    end
                end else if (!view.valid_ch) begin
                    status_next = STAT_INVALID;
                    if (req_reg == REQ_QUERY) begin
                        owner_out_next = OWNER_NONE;
                    end
                end else begin
                    case (req_reg)
                        REQ_FREE:      cmd.clear_used = 1'b1;
                        REQ_SET_OWNER: cmd.set_owner = 1'b1;
                        REQ_QUERY:     owner_out_next = view.owner;
                        REQ_OUT_PUSH: begin
                            if (view.out_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                out_en         = 1'b1;
                                out_we         = 1'b1;
                                cmd.out_wr_adv = 1'b1;
                                count_inc      = 1'b1;
                            end
                        end
                        REQ_OUT_POP: begin
                            if (view.out_empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                out_en         = 1'b1;
                                cmd.out_rd_adv = 1'b1;
                                count_inc      = 1'b1;
                                pop_next       = 1'b1;
                            end
                        end
                        REQ_IN_PUSH: begin
                            if (view.in_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                in_en         = 1'b1;
                                in_we         = 1'b1;
                                cmd.in_wr_adv = 1'b1;
                                count_inc     = 1'b1;
                            end
                        end
                        REQ_IN_POP: begin
                            if (view.in_empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                in_en         = 1'b1;
                                cmd.in_rd_adv = 1'b1;
                                count_inc     = 1'b1;
                                pop_next      = 1'b1;
                                pop_in_next   = 1'b1;
                            end
                        end
                        default: status_next = STAT_OK;
                    endcase
                end
                shown_next = (count_inc && count_reg != COUNT_MAX) ?
                             count_reg + 16'd1 : count_reg;
                count_next = last_reg ? 16'd0 : shown_next;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg      <= req_t'(s_req_type);
            channel_reg  <= s_channel;
            data_in_reg  <= s_data_in;
            owner_in_reg <= s_owner_in;
            last_reg     <= s_burst_last;
        end
        status_reg    <= status_next;
        chan_out_reg  <= chan_out_next;
        owner_out_reg <= owner_out_next;
        shown_reg     <= shown_next;
        pop_reg       <= pop_next;
        pop_in_reg    <= pop_in_next;
    end

    assign s_ready       = state_reg == ST_IDLE;
    assign m_valid       = state_reg == ST_RESULT;
    assign m_status      = status_reg;
    assign m_channel_out = chan_out_reg;
    assign m_owner_out   = owner_out_reg;
    assign m_burst_count = shown_reg;
    assign m_data_out    = pop_reg ? (pop_in_reg ? in_rdata : out_rdata) : 8'd0;

`ifndef SYNTH
    // An accepted beat is always worked on in the very next cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC)
        else $error("accepted beat not executed");

    // Failed pops and rejected requests never show ring data.
    a_no_data_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_EMPTY || m_status == STAT_INVALID ||
                    m_status == STAT_FULL || m_status == STAT_NOFREE)
        |-> m_data_out == 8'd0)
        else $error("data shown on a failed request");

    // A moved byte always leaves a nonzero count in the result.
    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC && count_inc |=> m_burst_count != 16'd0)
        else $error("byte moved but burst count is zero");

    // Only one ring memory is touched per beat.
    a_one_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_en && in_en))
        else $error("both ring memories accessed at once");
`endif

endmodule

`default_nettype wire
